// ===== rtl/core/tlws_pkg.sv =====
// ============================================================================
// tlws_pkg
// Shared widths, codes and transfer types of the three-level weighted sampler.
// ============================================================================
package tlws_pkg;

  localparam int SIDE_BITS  = 4;
  localparam int IDX_W      = 12;
  localparam int WEIGHT_W   = 16;
  localparam int GSUM_W     = 20;
  localparam int SSUM_W     = 24;
  localparam int TOTAL_W    = 28;
  localparam int FRAC_W     = 32;
  localparam int GRP_AW     = IDX_W - SIDE_BITS;
  localparam int SUP_AW     = GRP_AW - SIDE_BITS;
  localparam int TABLE_SIZE = 1 << IDX_W;
  localparam int NGROUPS    = 1 << GRP_AW;
  localparam int NSUPERS    = 1 << SUP_AW;

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_SAMPLE = 1'b1
  } opcode_t;

  typedef struct packed {
    opcode_t             opcode;
    logic [IDX_W-1:0]    entry_index;
    logic [WEIGHT_W-1:0] new_weight;
    logic [FRAC_W-1:0]   random_fraction;
  } req_t;

  typedef struct packed {
    logic [IDX_W-1:0]   sampled_index;
    logic [TOTAL_W-1:0] total_weight;
    logic               table_empty;
  } rsp_t;

endpackage

// ===== rtl/core/tlws_ram.sv =====
// ============================================================================
// tlws_ram
// Generic single-port synchronous RAM with a registered read.
// ============================================================================
module tlws_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== rtl/core/three_level_weighted_sampler_unit.sv =====
// ============================================================================
// three_level_weighted_sampler_unit
// Weight table with group, super-group and total sums; draws weighted samples.
// ============================================================================
// Usage:
// Items arrive on the req channel (req_valid, req_stall, req) and results
// leave on the rsp channel (rsp_valid, rsp_stall, rsp); a transfer happens
// when valid is high and stall is low. Each item gives exactly one result.
// A write item replaces one weight and updates its group sum, super-group
// sum and the total; it reads the old values, then writes the new ones.
// A sample item scales the fraction by the total in a multiply state and
// then walks the super-group, group and entry levels, one memory read per
// step: up to 16 steps a level. A zero total skips the walk and gives an
// empty-table result. The single read port of each memory sets this pace.
// One item is in flight at a time; a new item is taken once the previous
// result sits in the output register, even while the receiver stalls it.
// After reset a pass over all 4096 weight entries zeroes all memories;
// req_stall stays high during it. A stalled result is held until taken.
// ============================================================================
module three_level_weighted_sampler_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  tlws_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output tlws_pkg::rsp_t rsp
);

  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_WRD,
    S_WUP,
    S_MUL,
    S_SUP,
    S_GRP,
    S_ENT,
    S_OUT
  } state_t;

  state_t state;

  tlws_pkg::req_t                        r;
  tlws_pkg::rsp_t                        res;
  logic [tlws_pkg::IDX_W-1:0]            clr;
  logic [tlws_pkg::SIDE_BITS-1:0]        j;
  logic [tlws_pkg::SUP_AW-1:0]           sel_s;
  logic [tlws_pkg::GRP_AW-1:0]           sel_g;
  logic [tlws_pkg::TOTAL_W-1:0]          dart;
  logic [tlws_pkg::TOTAL_W-1:0]          total;

  logic [tlws_pkg::FRAC_W+tlws_pkg::TOTAL_W-1:0] prod;
  logic [tlws_pkg::TOTAL_W-1:0]          cur;
  logic                                  adv;
  logic [tlws_pkg::SIDE_BITS-1:0]        j_inc;

  logic                                  wt_we;
  logic [tlws_pkg::IDX_W-1:0]            wt_addr;
  logic [tlws_pkg::WEIGHT_W-1:0]         wt_wdata;
  logic [tlws_pkg::WEIGHT_W-1:0]         wt_rd;
  logic                                  grp_we;
  logic [tlws_pkg::GRP_AW-1:0]           grp_addr;
  logic [tlws_pkg::GSUM_W-1:0]           grp_wdata;
  logic [tlws_pkg::GSUM_W-1:0]           grp_rd;
  logic                                  sup_we;
  logic [tlws_pkg::SUP_AW-1:0]           sup_addr;
  logic [tlws_pkg::SSUM_W-1:0]           sup_wdata;
  logic [tlws_pkg::SSUM_W-1:0]           sup_rd;

  logic                                  accept;
  logic                                  out_free;

  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;
  assign out_free  = !rsp_valid || !rsp_stall;
  assign prod      = r.random_fraction * total;
  assign j_inc     = j + 1'b1;

  always_comb begin
    case (state)
      S_SUP:   cur = {{(tlws_pkg::TOTAL_W-tlws_pkg::SSUM_W){1'b0}}, sup_rd};
      S_GRP:   cur = {{(tlws_pkg::TOTAL_W-tlws_pkg::GSUM_W){1'b0}}, grp_rd};
      S_ENT:   cur = {{(tlws_pkg::TOTAL_W-tlws_pkg::WEIGHT_W){1'b0}}, wt_rd};
      default: cur = '0;
    endcase
    adv = (j != {tlws_pkg::SIDE_BITS{1'b1}}) && (cur <= dart);
  end

  always_comb begin
    wt_we     = 1'b0;
    grp_we    = 1'b0;
    sup_we    = 1'b0;
    wt_addr   = r.entry_index;
    grp_addr  = r.entry_index[tlws_pkg::IDX_W-1:tlws_pkg::SIDE_BITS];
    sup_addr  = r.entry_index[tlws_pkg::IDX_W-1:tlws_pkg::IDX_W-tlws_pkg::SUP_AW];
    wt_wdata  = r.new_weight;
    grp_wdata = grp_rd - {{(tlws_pkg::GSUM_W-tlws_pkg::WEIGHT_W){1'b0}}, wt_rd}
                + {{(tlws_pkg::GSUM_W-tlws_pkg::WEIGHT_W){1'b0}}, r.new_weight};
    sup_wdata = sup_rd - {{(tlws_pkg::SSUM_W-tlws_pkg::WEIGHT_W){1'b0}}, wt_rd}
                + {{(tlws_pkg::SSUM_W-tlws_pkg::WEIGHT_W){1'b0}}, r.new_weight};
    case (state)
      S_CLR: begin
        wt_we     = 1'b1;
        grp_we    = 1'b1;
        sup_we    = 1'b1;
        wt_addr   = clr;
        grp_addr  = clr[tlws_pkg::GRP_AW-1:0];
        sup_addr  = clr[tlws_pkg::SUP_AW-1:0];
        wt_wdata  = '0;
        grp_wdata = '0;
        sup_wdata = '0;
      end
      S_WUP: begin
        wt_we  = 1'b1;
        grp_we = 1'b1;
        sup_we = 1'b1;
      end
      S_MUL: begin
        sup_addr = '0;
      end
      S_SUP: begin
        sup_addr = j_inc;
        grp_addr = {j, {tlws_pkg::SIDE_BITS{1'b0}}};
      end
      S_GRP: begin
        grp_addr = {sel_s, j_inc};
        wt_addr  = {sel_s, j, {tlws_pkg::SIDE_BITS{1'b0}}};
      end
      S_ENT: begin
        wt_addr = {sel_g, j_inc};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      clr       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall && state != S_OUT) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_CLR: begin
          clr <= clr + 1'b1;
          if (clr == {tlws_pkg::IDX_W{1'b1}}) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            r <= req;
            state <= (req.opcode == tlws_pkg::OP_WRITE) ? S_WRD : S_MUL;
          end
        end
        S_WRD: begin
          state <= S_WUP;
        end
        S_WUP: begin
          total <= total
                   - {{(tlws_pkg::TOTAL_W-tlws_pkg::WEIGHT_W){1'b0}}, wt_rd}
                   + {{(tlws_pkg::TOTAL_W-tlws_pkg::WEIGHT_W){1'b0}}, r.new_weight};
          res.sampled_index <= r.entry_index;
          res.total_weight  <= total
                   - {{(tlws_pkg::TOTAL_W-tlws_pkg::WEIGHT_W){1'b0}}, wt_rd}
                   + {{(tlws_pkg::TOTAL_W-tlws_pkg::WEIGHT_W){1'b0}}, r.new_weight};
          res.table_empty   <= 1'b0;
          state <= S_OUT;
        end
        S_MUL: begin
          dart <= prod[tlws_pkg::FRAC_W+tlws_pkg::TOTAL_W-1:tlws_pkg::FRAC_W];
          j    <= '0;
          if (total == '0) begin
            res.sampled_index <= '0;
            res.total_weight  <= total;
            res.table_empty   <= 1'b1;
            state <= S_OUT;
          end else begin
            state <= S_SUP;
          end
        end
        S_SUP: begin
          if (adv) begin
            dart <= dart - cur;
            j    <= j_inc;
          end else begin
            sel_s <= j;
            j     <= '0;
            state <= S_GRP;
          end
        end
        S_GRP: begin
          if (adv) begin
            dart <= dart - cur;
            j    <= j_inc;
          end else begin
            sel_g <= {sel_s, j};
            j     <= '0;
            state <= S_ENT;
          end
        end
        S_ENT: begin
          if (adv) begin
            dart <= dart - cur;
            j    <= j_inc;
          end else begin
            res.sampled_index <= {sel_g, j};
            res.total_weight  <= total;
            res.table_empty   <= 1'b0;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            rsp       <= res;
            rsp_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (state == S_CLR) begin
        total <= '0;
      end
    end
  end

  tlws_ram #(
    .WIDTH(tlws_pkg::WEIGHT_W),
    .DEPTH(tlws_pkg::TABLE_SIZE)
  ) u_weights (
    .clk  (clk),
    .we   (wt_we),
    .addr (wt_addr),
    .wdata(wt_wdata),
    .rdata(wt_rd)
  );

  tlws_ram #(
    .WIDTH(tlws_pkg::GSUM_W),
    .DEPTH(tlws_pkg::NGROUPS)
  ) u_groups (
    .clk  (clk),
    .we   (grp_we),
    .addr (grp_addr),
    .wdata(grp_wdata),
    .rdata(grp_rd)
  );

  tlws_ram #(
    .WIDTH(tlws_pkg::SSUM_W),
    .DEPTH(tlws_pkg::NSUPERS)
  ) u_supers (
    .clk  (clk),
    .we   (sup_we),
    .addr (sup_addr),
    .wdata(sup_wdata),
    .rdata(sup_rd)
  );

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    accept |=> req_stall)
    else $error("Input taken while an item is still in flight.");

  a_ram_write_phase: assert property (@(posedge clk) disable iff (rst)
    (wt_we || grp_we || sup_we) |-> (state == S_CLR || state == S_WUP))
    else $error("Memory written outside the clearing pass or a weight update.");

  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.table_empty) |->
      (rsp.sampled_index == '0 && rsp.total_weight == '0))
    else $error("Empty-table result carries an index or a non-zero total.");

  a_result_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state == S_OUT))
    else $error("Result raised without a finished item.");

endmodule
